FILE: rtl/sact_pkg.sv
// Shared types and command codes of the cache tag and LRU controller.
package sact_pkg;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_FILL   = 2'd1;
	localparam logic [1:0] CMD_EVICT  = 2'd2;
	localparam logic [1:0] CMD_RETAG  = 2'd3;

	localparam int ADDR_W = 32;

	// Controller to datapath.
	typedef struct packed {
		logic load;   // capture the input item
		logic read;   // read the set from the stores
		logic decide; // register the search results
		logic write;  // update stores and result
	} sact_cmd_t;

	// Datapath to controller: nothing beyond the item kind is needed.
	typedef struct packed {
		logic [1:0] cmd;
	} sact_stat_t;

endpackage

FILE: rtl/set_assoc_cache_tag_lru_core.sv
// Top level of the set-associative cache tag and true-LRU controller.
// Each item passes through the read, decide and write states; the result is registered
// in the write state and held while the master side stalls. The single-port tag and rank memories
// are read and then written back for each item, so items run one at a time.
// Reset (arst_n, asynchronous, active low) clears valid bits and rank-row marks at
// once: a set whose ranks were never written reads as way 0 least recent.
module set_assoc_cache_tag_lru_core import sact_pkg::*; #(
	parameter int SETS        = 64,
	parameter int WAYS        = 4,
	parameter int BLOCK_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata from bit 0: cmd[1:0], addr[33:2], way_sel[35:34], new_addr[67:36],
	// retag_set[73:68], zero fill to 80 bits
	input  logic [79:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata from bit 0: found[0], way_out[2:1], free_found[3], free_way[5:4], zero fill
	output logic [7:0]  m_tdata
);

	sact_cmd_t  ctl;
	sact_stat_t stat;
	logic       found, free_found;
	logic [1:0] way_out, free_way;

	// The controller sequences each item; the datapath holds the stores and the
	// result register, which stays put while the master side stalls.
	sact_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.stat, .ctl
	);

	sact_dp #(.SETS(SETS), .WAYS(WAYS), .BLOCK_BYTES(BLOCK_BYTES)) u_dp (
		.clk, .arst_n, .ctl, .stat,
		.cmd(s_tdata[1:0]), .addr(s_tdata[33:2]), .way_sel(s_tdata[35:34]),
		.new_addr(s_tdata[67:36]), .retag_set(s_tdata[73:68]),
		.found, .way_out, .free_found, .free_way
	);

	assign m_tdata = {2'b00, free_way, free_found, way_out, found};

endmodule

FILE: rtl/sact_ctrl.sv
// Controller state machine of the cache tag and LRU controller.
module sact_ctrl import sact_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  sact_stat_t stat,
	output sact_cmd_t  ctl
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_READ   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_WRITE  = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	logic [2:0] state_q;
	logic       busy;

	assign busy      = (state_q != ST_IDLE) && (state_q != ST_OUT);
	assign out_valid = (state_q == ST_OUT);
	assign in_ready  = (state_q == ST_IDLE) || (state_q == ST_OUT && out_ready);

	always_comb begin
		ctl.load   = in_valid && in_ready;
		ctl.read   = (state_q == ST_READ);
		ctl.decide = (state_q == ST_DECIDE);
		ctl.write  = (state_q == ST_WRITE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:   if (in_valid) state_q <= ST_READ;
				ST_READ:   state_q <= ST_DECIDE;
				ST_DECIDE: state_q <= ST_WRITE;
				ST_WRITE:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_ready) state_q <= in_valid ? ST_READ : ST_IDLE;
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	logic unused_ok;
	assign unused_ok = busy ^ stat.cmd[0] ^ stat.cmd[1];

endmodule

FILE: rtl/sact_dp.sv
// Datapath of the cache tag and LRU controller: stores, search and update.
module sact_dp import sact_pkg::*; #(
	parameter int SETS        = 64,
	parameter int WAYS        = 4,
	parameter int BLOCK_BYTES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sact_cmd_t         ctl,
	output sact_stat_t        stat,
	input  logic [1:0]        cmd,
	input  logic [31:0]       addr,
	input  logic [1:0]        way_sel,
	input  logic [31:0]       new_addr,
	input  logic [5:0]        retag_set,
	output logic              found,
	output logic [1:0]        way_out,
	output logic              free_found,
	output logic [1:0]        free_way
);

	localparam int OB    = $clog2(BLOCK_BYTES + 1) - 1;
	localparam int IB    = $clog2(SETS + 1) - 1;
	localparam int IBW   = (IB > 0) ? IB : 1;
	localparam int TSH   = OB + IB;
	localparam int TW    = (TSH >= ADDR_W) ? 1 : ADDR_W - TSH;
	localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NE    = SETS * WAYS;

	typedef logic [TW-1:0] tag_t;
	typedef logic [WW-1:0] rank_t;

	// Item registers.
	logic [1:0]  cmd_q;
	logic [1:0]  wsel_q;
	logic [IBW-1:0] set_q;
	tag_t        tag_q, ntag_q;
	logic        rset_ok_q;

	// Stores: one row of tags per set and one row of ranks per set in memories,
	// valid bits in flip-flops.
	logic [WAYS*TW-1:0] tag_mem [SETS];
	logic [WAYS*WW-1:0] rank_mem [SETS];
	logic [NE-1:0] valid_q;
	logic [SETS-1:0] rank_init_q; // set rank row written since reset

	logic [WAYS*TW-1:0] rd_row_s1;
	tag_t  rd_tag_s1 [WAYS];
	logic [WAYS*WW-1:0] rd_rank_s1;
	logic rd_rinit_s1;

	function automatic tag_t tag_of(input logic [31:0] a);
		if (TSH >= ADDR_W) return '0;
		return TW'(a >> TSH);
	endfunction

	function automatic logic [IBW-1:0] set_of(input logic [31:0] a);
		if (IB == 0) return '0;
		return IBW'(a >> OB);
	endfunction

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd;
			wsel_q <= way_sel;
			tag_q  <= tag_of(addr);
			ntag_q <= tag_of(new_addr);
			if (cmd == CMD_RETAG) begin
				set_q     <= IBW'(retag_set);
				rset_ok_q <= (32'(retag_set) < SETS);
			end else begin
				set_q     <= set_of(addr);
				rset_ok_q <= 1'b1;
			end
		end
	end

	assign stat.cmd = cmd_q;

	// Read of the set: one tag row and one rank row.
	always_ff @(posedge clk) begin
		if (ctl.read) begin
			rd_row_s1  <= tag_mem[set_q];
			rd_rank_s1 <= rank_mem[set_q];
		end
	end

	always_comb begin
		for (int w = 0; w < WAYS; w++)
			rd_tag_s1[w] = rd_row_s1[w*TW +: TW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_rinit_s1 <= 1'b0;
		else if (ctl.read) rd_rinit_s1 <= rank_init_q[set_q];
	end

	// Search logic over the ways.
	rank_t ranks [WAYS];
	logic [WAYS-1:0] vld;
	logic hit;   rank_t hit_w;
	logic fre;   rank_t fre_w;
	rank_t lru_w;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			ranks[w] = rd_rinit_s1 ? rd_rank_s1[w*WW +: WW] : WW'(w);
			vld[w]   = valid_q[32'(set_q) * WAYS + w];
		end
		hit = 1'b0; hit_w = '0;
		for (int w = WAYS - 1; w >= 0; w--)
			if (vld[w] && rd_tag_s1[w] == tag_q) begin
				hit = 1'b1; hit_w = WW'(w);
			end
		fre = 1'b0; fre_w = '0;
		for (int w = 0; w < WAYS; w++)
			if (!vld[w]) begin
				fre = 1'b1; fre_w = WW'(w);
			end
		lru_w = '0;
		for (int w = WAYS - 1; w >= 0; w--)
			if (ranks[w] == '0) lru_w = WW'(w);
	end

	// Decision per command.
	logic  d_wr, d_touch, d_found, d_ffound;
	rank_t d_way, d_fway;
	tag_t  d_wtag;

	always_comb begin
		d_ffound = 1'b0; d_fway = '0; d_wtag = tag_q;
		d_wr = 1'b0; d_touch = 1'b0; d_found = 1'b0; d_way = '0;
		case (cmd_q)
			CMD_LOOKUP: begin
				d_found = hit; d_way = hit ? hit_w : '0;
				d_touch = hit; d_ffound = fre; d_fway = fre_w;
			end
			CMD_FILL: begin
				if (32'(wsel_q) < WAYS) begin
					d_found = 1'b1; d_way = WW'(wsel_q);
					d_wr = 1'b1; d_touch = 1'b1;
				end
			end
			CMD_EVICT: begin
				d_found = 1'b1; d_way = lru_w;
				d_wr = 1'b1; d_touch = 1'b1;
			end
			default: begin
				if (rset_ok_q && hit) begin
					d_found = 1'b1; d_way = hit_w; d_wtag = ntag_q;
					d_wr = 1'b1; d_touch = 1'b1;
				end
			end
		endcase
	end

	// Decision registers.
	logic  do_wr_s2, do_touch_s2, found_s2, ffound_s2;
	rank_t way_s2, fway_s2;
	tag_t  wtag_s2;
	logic [WAYS*WW-1:0] rank_s2;

	always_ff @(posedge clk) begin
		if (ctl.decide) begin
			for (int w = 0; w < WAYS; w++) rank_s2[w*WW +: WW] <= ranks[w];
			ffound_s2   <= d_ffound;
			fway_s2     <= d_fway;
			wtag_s2     <= d_wtag;
			do_wr_s2    <= d_wr;
			do_touch_s2 <= d_touch;
			found_s2    <= d_found;
			way_s2      <= d_way;
		end
	end

	// Update: tag row write, rank update and result.
	logic [WAYS*WW-1:0] new_rank;
	logic [WAYS*TW-1:0] wr_row;
	rank_t r0;
	always_comb begin
		r0 = rank_s2[32'(way_s2)*WW +: WW];
		new_rank = rank_s2;
		for (int w = 0; w < WAYS; w++)
			if (rank_s2[w*WW +: WW] > r0) new_rank[w*WW +: WW] = rank_s2[w*WW +: WW] - 1'b1;
		new_rank[32'(way_s2)*WW +: WW] = WW'(WAYS - 1);
		wr_row = rd_row_s1;
		wr_row[32'(way_s2)*TW +: TW] = wtag_s2;
	end

	always_ff @(posedge clk) begin
		if (ctl.write && do_wr_s2) tag_mem[set_q] <= wr_row;
		if (ctl.write && do_touch_s2) rank_mem[set_q] <= new_rank;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rank_init_q <= '0;
		end else if (ctl.write) begin
			if (do_wr_s2) valid_q[32'(set_q) * WAYS + 32'(way_s2)] <= 1'b1;
			if (do_touch_s2) rank_init_q[set_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.write) begin
			found      <= found_s2;
			way_out    <= 2'(way_s2);
			free_found <= ffound_s2;
			free_way   <= 2'(fway_s2);
		end
	end

endmodule

FILE: rtl/sact_checker.sv
// Port-level checker of the cache tag and LRU controller, with its bind.
module sact_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while busy");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> ##3 m_tvalid)
		else $error("result late");

	a_not_found_way0: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[2:1] == 2'd0)
		else $error("way nonzero on miss");

endmodule

bind set_assoc_cache_tag_lru_core sact_checker u_sact_checker (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

FILE: sim/tb_set_assoc_cache_tag_lru_core.sv
// Self-checking testbench of the cache tag and LRU controller with random stalls on both sides.
module tb_set_assoc_cache_tag_lru_core import sact_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSETS = 64;
	localparam int NWAYS = 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	set_assoc_cache_tag_lru_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #4 clk = ~clk;

	// Predicted copy of the cache directory.
	logic [19:0] tags  [NSETS][NWAYS];
	logic        valid [NSETS][NWAYS];
	int          rank  [NSETS][NWAYS];

	logic [79:0] pending_items[$];
	logic [5:0]  expected_results[$];
	int          send_idle_pct = 16;
	int          recv_idle_pct = 52;
	bit          hold_sender   = 1'b0;
	int          mismatches    = 0;
	int          results_seen  = 0;
	int          hits_seen     = 0;

	function automatic void make_recent(int s, int w);
		int r;
		r = rank[s][w];
		for (int i = 0; i < NWAYS; i++)
			if (rank[s][i] > r) rank[s][i]--;
		rank[s][w] = NWAYS - 1;
	endfunction

	// Applies one command to the predicted directory; returns the packed result.
	function automatic logic [5:0] predict_directory(logic [79:0] item);
		logic [1:0]  cmd;
		logic [31:0] addr, naddr;
		logic [1:0]  wsel;
		logic [5:0]  rset, s;
		logic [19:0] tg;
		logic        fnd, ffnd;
		logic [1:0]  way, fway;
		cmd = item[1:0]; addr = item[33:2]; wsel = item[35:34];
		naddr = item[67:36]; rset = item[73:68];
		s = addr[11:6]; tg = addr[31:12];
		fnd = 1'b0; way = 2'd0; ffnd = 1'b0; fway = 2'd0;
		case (cmd)
			CMD_LOOKUP: begin
				for (int w = 0; w < NWAYS; w++)
					if (!fnd && valid[s][w] && tags[s][w] == tg) begin
						fnd = 1'b1; way = 2'(w);
					end
				if (fnd) make_recent(s, way);
				for (int w = 0; w < NWAYS; w++)
					if (!valid[s][w]) begin
						ffnd = 1'b1; fway = 2'(w);
					end
			end
			CMD_FILL: begin
				tags[s][wsel] = tg; valid[s][wsel] = 1'b1; make_recent(s, wsel);
				fnd = 1'b1; way = wsel;
			end
			CMD_EVICT: begin
				for (int w = NWAYS - 1; w >= 0; w--)
					if (rank[s][w] == 0) way = 2'(w);
				tags[s][way] = tg; valid[s][way] = 1'b1; make_recent(s, way);
				fnd = 1'b1;
			end
			default: begin
				for (int w = 0; w < NWAYS; w++)
					if (!fnd && valid[rset][w] && tags[rset][w] == tg) begin
						fnd = 1'b1; way = 2'(w);
					end
				if (fnd) begin
					tags[rset][way] = naddr[31:12];
					make_recent(rset, way);
				end
			end
		endcase
		return {fway, ffnd, way, fnd};
	endfunction

	function automatic logic [79:0] pack_item(logic [1:0] cmd, logic [31:0] addr,
			logic [1:0] wsel, logic [31:0] naddr, logic [5:0] rset);
		return {6'd0, rset, naddr, wsel, addr, cmd};
	endfunction

	// A small pool of tags and sets keeps hits, evictions and retags frequent.
	function automatic logic [31:0] pool_addr();
		logic [31:0] a;
		a = $urandom;
		if ($urandom_range(0, 9) < 8) begin
			a[31:12] = $urandom_range(0, 5) == 0 ? 20'hFFFFF : 20'(($urandom_range(0, 5)));
			a[11:6]  = 6'($urandom_range(0, 3));
		end
		return a;
	endfunction

	// Sender: a new item is offered once the previous one has been taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() > 0 && !hold_sender &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					s_tdata  <= pending_items.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_directory(s_tdata));
			m_tready <= $urandom_range(0, 99) >= recv_idle_pct;
		end
	end

	// Monitor: each accepted result is checked against the oldest prediction.
	always @(posedge clk) begin
		logic [5:0] exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result item %h with nothing predicted.", m_tdata);
			end else begin
				exp_res = expected_results.pop_front();
				if (exp_res[0]) hits_seen++;
				if (m_tdata[5:0] !== exp_res || m_tdata[7:6] !== 2'b00) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result %0d: expected found %b way %0d free %b/%0d, got %h.",
							results_seen, exp_res[0], exp_res[2:1], exp_res[3],
							exp_res[5:4], m_tdata);
				end
			end
		end
	end

	task automatic drain();
		while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	task automatic queue_random(int count);
		logic [1:0] cmd;
		for (int i = 0; i < count; i++) begin
			cmd = 2'($urandom_range(0, 3));
			pending_items.push_back(pack_item(cmd, pool_addr(), 2'($urandom),
				pool_addr(), $urandom_range(0, 9) < 7 ? 6'($urandom_range(0, 3)) : 6'($urandom)));
		end
	endtask

	initial begin
		for (int s = 0; s < NSETS; s++)
			for (int w = 0; w < NWAYS; w++) begin
				valid[s][w] = 1'b0; rank[s][w] = w; tags[s][w] = '0;
			end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: lookups on empty sets, fills of every way, hit order,
		// LRU eviction, retag hit and miss, and extreme address values.
		pending_items.push_back(pack_item(CMD_LOOKUP, 32'h0, 2'd0, 32'h0, 6'd0));
		pending_items.push_back(pack_item(CMD_LOOKUP, 32'hFFFFFFFF, 2'd0, 32'h0, 6'd0));
		pending_items.push_back(pack_item(CMD_EVICT, 32'h0000_0040, 2'd0, 32'h0, 6'd0));
		for (int w = 0; w < NWAYS; w++)
			pending_items.push_back(pack_item(CMD_FILL, 32'h0000_5000, 2'(w), 32'h0, 6'd0));
		pending_items.push_back(pack_item(CMD_LOOKUP, 32'h0000_5000, 2'd0, 32'h0, 6'd0));
		pending_items.push_back(pack_item(CMD_LOOKUP, 32'h0000_6000, 2'd0, 32'h0, 6'd0));
		pending_items.push_back(pack_item(CMD_EVICT, 32'hFFFF_F000, 2'd0, 32'h0, 6'd0));
		pending_items.push_back(pack_item(CMD_EVICT, 32'h1234_5000, 2'd0, 32'h0, 6'd0));
		pending_items.push_back(pack_item(CMD_RETAG, 32'h0000_5000, 2'd0, 32'hABCD_E000,
			6'd0));
		pending_items.push_back(pack_item(CMD_RETAG, 32'h0000_5000, 2'd0, 32'hFFFFFFFF,
			6'd0));
		pending_items.push_back(pack_item(CMD_RETAG, 32'h0000_7000, 2'd3, 32'h0, 6'd63));
		pending_items.push_back(pack_item(CMD_FILL, 32'hFFFFFFFF, 2'd3, 32'hFFFFFFFF, 6'd63));
		pending_items.push_back(pack_item(CMD_RETAG, 32'hFFFFFFFF, 2'd3, 32'h0, 6'd63));
		pending_items.push_back(pack_item(CMD_LOOKUP, 32'h0000_0FC0, 2'd0, 32'h0, 6'd63));
		pending_items.push_back(pack_item(CMD_LOOKUP, 32'h0000_0FFF, 2'd0, 32'h0, 6'd0));
		drain();

		// Part way through, the sender waits until every predicted result has arrived.
		queue_random(600);
		while (pending_items.size() > 300)
			@(posedge clk);
		hold_sender = 1'b1;
		while (s_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		hold_sender = 1'b0;
		drain();

		send_idle_pct = 52; recv_idle_pct = 16;
		queue_random(650);
		drain();
		send_idle_pct = 0; recv_idle_pct = 0;
		queue_random(650);
		drain();
		repeat (12) @(posedge clk);

		$display("Checked %0d results (%0d hits or writes) over lookup, fill, evict and retag.",
			results_seen, hits_seen);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("set_assoc_cache_tag_lru_core: match");
		else
			$display("set_assoc_cache_tag_lru_core: mismatch");
		$finish;
	end

	// Watchdog for a block that stops answering.
	initial begin
		#2ms;
		$display("Timed out with %0d results outstanding.", expected_results.size());
		$display("set_assoc_cache_tag_lru_core: mismatch");
		$finish;
	end

endmodule
